// ----- rtl/min_max_range_normalizer_defines.svh -----
// Assertion macros for the min/max range normalizer checker.
// Included by the checker file only; depends on nothing else.
`ifndef MIN_MAX_RANGE_NORMALIZER_DEFINES_SVH
`define MIN_MAX_RANGE_NORMALIZER_DEFINES_SVH

// Check a property while reset is released.
`define MMRN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mmrn assertion failed");

// Check a property at every edge, reset included.
`define MMRN_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mmrn assertion failed");

`endif

// ----- rtl/mmrn_pkg.sv -----
// Shared types and constants of the min/max range normalizer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mmrn_pkg;

    localparam int unsigned SEQ_DEPTH_DEF = 64;
    localparam int unsigned SEQ_DEPTH_MAX = 64;
    localparam int unsigned IDX_MAX_W     = $clog2(SEQ_DEPTH_MAX);
    localparam int unsigned DATA_W        = 16;
    localparam int unsigned DIV_STEPS     = DATA_W;
    localparam int unsigned JOBQ_DEPTH    = 2;
    localparam int unsigned CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 1'b1;

    typedef logic signed [DATA_W-1:0] t_sample;

    typedef struct packed {
        logic                 bank;
        logic [IDX_MAX_W-1:0] last_idx;
        t_sample              lo;
        t_sample              hi;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

`default_nettype wire

// ----- rtl/min_max_range_normalizer.sv -----
// Min/max range normalizer. Samples enter at one per cycle while a store bank is free.
// Each sample is read, multiplied, passed through 16 divide steps (none for a flat run)
// and output before the next is read, since the back end has a single divider.
// Two store banks let the next sequence load while the previous one drains.
// Reset: synchronous, active low; clears control and config registers, store untouched.
`default_nettype none

module min_max_range_normalizer #(
    parameter int unsigned SEQ_DEPTH = mmrn_pkg::SEQ_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mmrn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mmrn_pkg::DATA_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mmrn_pkg::t_sample                  i_sample,
    input  logic                               i_end_of_sequence,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mmrn_pkg::t_sample                  o_scaled_value,
    output logic                               o_last_of_run,
    output logic                               o_flat_input
);
    import mmrn_pkg::*;

    localparam int unsigned IW = $clog2(SEQ_DEPTH);

    t_sample       r_out_min;
    t_sample       r_out_max;
    t_release      release_bank;
    logic          wr_en;
    logic [IW:0]   wr_addr;
    t_sample       wr_data;
    logic [IW:0]   rd_addr;
    t_sample       rd_data;
    logic          push;
    t_job          push_job;
    logic          pop;
    logic          job_nonempty;
    t_job          head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= '0;
            r_out_max <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OUT_MIN: r_out_min <= i_cfg_data;
                REG_OUT_MAX: r_out_max <= i_cfg_data;
                default:     r_out_min <= r_out_min;
            endcase
        end
    end

    mmrn_front #(.SEQ_DEPTH(SEQ_DEPTH)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_sample          (i_sample),
        .i_end_of_sequence (i_end_of_sequence),
        .o_in_stall        (o_in_stall),
        .i_release         (release_bank),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data),
        .o_push            (push),
        .o_job             (push_job)
    );

    mmrn_store #(.SEQ_DEPTH(SEQ_DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    mmrn_jobq u_jobq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_nonempty (job_nonempty),
        .o_job      (head_job)
    );

    mmrn_back #(.SEQ_DEPTH(SEQ_DEPTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_out_min      (r_out_min),
        .i_out_max      (r_out_max),
        .i_job_nonempty (job_nonempty),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_release      (release_bank),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scaled_value (o_scaled_value),
        .o_last_of_run  (o_last_of_run),
        .o_flat_input   (o_flat_input)
    );

endmodule

`default_nettype wire

// ----- rtl/mmrn_front.sv -----
// Front end: accepts samples, writes them to the store, tracks min and max.
// Hands a finished sequence to the job queue; uses mmrn_pkg.
`default_nettype none

module mmrn_front #(
    parameter int unsigned SEQ_DEPTH = mmrn_pkg::SEQ_DEPTH_DEF,
    localparam int unsigned IW = $clog2(SEQ_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  mmrn_pkg::t_sample  i_sample,
    input  logic               i_end_of_sequence,
    output logic               o_in_stall,
    input  mmrn_pkg::t_release i_release,
    output logic               o_wr_en,
    output logic [IW:0]        o_wr_addr,
    output mmrn_pkg::t_sample  o_wr_data,
    output logic               o_push,
    output mmrn_pkg::t_job     o_job
);
    import mmrn_pkg::*;

    logic [IW-1:0] r_cnt;
    logic          r_bank;
    logic [1:0]    r_busy;
    logic [1:0]    n_busy;
    t_sample       r_lo;
    t_sample       r_hi;
    t_sample       n_lo;
    t_sample       n_hi;
    logic          accept;
    logic          first;
    logic          seq_end;

    assign accept  = i_in_valid && !r_busy[r_bank];
    assign first   = (r_cnt == '0);
    assign seq_end = i_end_of_sequence || (r_cnt == IW'(SEQ_DEPTH - 1));

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (first) begin
            n_lo = i_sample;
            n_hi = i_sample;
        end else if (i_sample < r_lo) begin
            n_lo = i_sample;
        end else if (i_sample > r_hi) begin
            n_hi = i_sample;
        end
    end

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (o_push) begin
            n_busy[r_bank] = 1'b1;
        end
    end

    assign o_in_stall = r_busy[r_bank];
    assign o_wr_en    = accept;
    assign o_wr_addr  = {r_bank, r_cnt};
    assign o_wr_data  = i_sample;
    assign o_push     = accept && seq_end;
    assign o_job      = '{bank: r_bank, last_idx: IDX_MAX_W'(r_cnt), lo: n_lo, hi: n_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
                if (seq_end) begin
                    r_cnt  <= '0;
                    r_bank <= !r_bank;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mmrn_store.sv -----
// Two-bank sample store: one write port, one read port with registered data.
// Front fills one bank while back end drains the other; uses mmrn_pkg.
`default_nettype none

module mmrn_store #(
    parameter int unsigned SEQ_DEPTH = mmrn_pkg::SEQ_DEPTH_DEF,
    localparam int unsigned AW = $clog2(SEQ_DEPTH) + 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  mmrn_pkg::t_sample i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output mmrn_pkg::t_sample o_rd_data
);
    import mmrn_pkg::*;

    localparam int unsigned MEM_DEPTH = 2 ** AW;

    t_sample r_mem [MEM_DEPTH];
    t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/mmrn_jobq.sv -----
// Short queue of finished sequences between front end and back end.
// Each entry names a store bank, its last index and its extremes; uses mmrn_pkg.
`default_nettype none

module mmrn_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mmrn_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_nonempty,
    output mmrn_pkg::t_job o_job
);
    import mmrn_pkg::*;

    localparam int unsigned PW = $clog2(JOBQ_DEPTH);
    localparam int unsigned CW = $clog2(JOBQ_DEPTH + 1);

    t_job          r_ent [JOBQ_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_ent[r_rp];
    assign do_push    = i_push && (r_cnt != CW'(JOBQ_DEPTH));
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_ent[r_wp] <= i_job;
                r_wp        <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mmrn_back.sv -----
// Back end: reads each stored sample, scales it (multiplier, radix-2 divider),
// saturates it, holds it in the output register (out_min if flat); uses mmrn_pkg.
`default_nettype none

module mmrn_back #(
    parameter int unsigned SEQ_DEPTH = mmrn_pkg::SEQ_DEPTH_DEF,
    localparam int unsigned IW = $clog2(SEQ_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mmrn_pkg::t_sample  i_out_min,
    input  mmrn_pkg::t_sample  i_out_max,
    input  logic               i_job_nonempty,
    input  mmrn_pkg::t_job     i_job,
    output logic               o_pop,
    output logic [IW:0]        o_rd_addr,
    input  mmrn_pkg::t_sample  i_rd_data,
    output mmrn_pkg::t_release o_release,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mmrn_pkg::t_sample  o_scaled_value,
    output logic               o_last_of_run,
    output logic               o_flat_input
);
    import mmrn_pkg::*;

    localparam int unsigned SW = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [IW-1:0]       r_idx;
    logic [SW-1:0]       r_step;
    logic                r_neg;
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_quo;
    logic                r_ovalid;
    t_sample             r_value;
    logic                r_last;
    logic                r_flat;

    logic                flat;
    logic                is_last;
    logic                emit_ok;
    logic                emit;
    logic [DATA_W:0]     span_in_w;
    logic [DATA_W-1:0]   span_in;
    logic [DATA_W:0]     diff_w;
    logic [DATA_W-1:0]   diff;
    logic [DATA_W:0]     span_out;
    logic                so_neg;
    logic [DATA_W:0]     so_abs;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0]     trial;
    logic [DATA_W:0]     trial_sub;
    logic                trial_ge;
    logic [DATA_W+1:0]   q_ext;
    logic [DATA_W+1:0]   q_signed;
    logic [DATA_W+1:0]   sum;
    t_sample             sat;
    t_sample             result;

    assign flat    = (r_job.hi == r_job.lo);
    assign is_last = (r_idx == r_job.last_idx[IW-1:0]);
    assign emit_ok = !r_ovalid || !i_out_stall;
    assign emit    = (r_state == S_EMIT) && emit_ok;

    always_comb begin
        span_in_w = {r_job.hi[DATA_W-1], r_job.hi} - {r_job.lo[DATA_W-1], r_job.lo};
        span_in   = span_in_w[DATA_W-1:0];
        diff_w    = {i_rd_data[DATA_W-1], i_rd_data} - {r_job.lo[DATA_W-1], r_job.lo};
        diff      = diff_w[DATA_W-1:0];
        span_out  = {i_out_max[DATA_W-1], i_out_max} - {i_out_min[DATA_W-1], i_out_min};
        so_neg    = span_out[DATA_W];
        so_abs    = so_neg ? (~span_out + 1'b1) : span_out;
        prod      = diff * so_abs[DATA_W-1:0];
    end

    always_comb begin
        trial     = {r_rem, r_quo[DATA_W-1]};
        trial_sub = trial - {1'b0, span_in};
        trial_ge  = (trial >= {1'b0, span_in});
    end

    always_comb begin
        q_ext    = {2'b00, r_quo};
        q_signed = r_neg ? (~q_ext + 1'b1) : q_ext;
        sum      = {{2{i_out_min[DATA_W-1]}}, i_out_min} + q_signed;
        if ((sum[DATA_W+1:DATA_W-1] == 3'b000) || (sum[DATA_W+1:DATA_W-1] == 3'b111)) begin
            sat = sum[DATA_W-1:0];
        end else if (sum[DATA_W+1]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        result = flat ? i_out_min : sat;
    end

    assign o_pop             = (r_state == S_IDLE) && i_job_nonempty;
    assign o_rd_addr         = {r_job.bank, r_idx};
    assign o_release.valid   = emit && is_last;
    assign o_release.bank    = r_job.bank;
    assign o_out_valid       = r_ovalid;
    assign o_scaled_value    = r_value;
    assign o_last_of_run     = r_last;
    assign o_flat_input      = r_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && !emit) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_nonempty) begin
                        r_job   <= i_job;
                        r_idx   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_rem   <= prod[2*DATA_W-1:DATA_W];
                    r_quo   <= prod[DATA_W-1:0];
                    r_neg   <= so_neg;
                    r_step  <= '0;
                    r_state <= flat ? S_EMIT : S_DIV;
                end
                S_DIV: begin
                    r_rem  <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
                    r_quo  <= {r_quo[DATA_W-2:0], trial_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == SW'(DIV_STEPS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_ovalid <= 1'b1;
                        r_value  <= result;
                        r_last   <= is_last;
                        r_flat   <= flat;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mmrn_checker.sv -----
// Port-level checker for the min/max range normalizer, bound to the top level.
// Uses the macros of min_max_range_normalizer_defines.svh and mmrn_pkg.
`default_nettype none
`include "min_max_range_normalizer_defines.svh"

module mmrn_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           o_in_stall,
    input  wire logic                           o_out_valid,
    input  wire logic                           i_out_stall,
    input  wire mmrn_pkg::t_sample              o_scaled_value,
    input  wire logic                           o_last_of_run,
    input  wire logic                           o_flat_input
);
    import mmrn_pkg::*;

    logic [DATA_W+1:0] out_word;
    logic              in_take;

    assign out_word = {o_scaled_value, o_last_of_run, o_flat_input};
    assign in_take  = i_in_valid && !o_in_stall;

    `MMRN_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)
    `MMRN_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(out_word))
    `MMRN_ASSERT(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall) |-> $past(in_take))
    `MMRN_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule

bind min_max_range_normalizer mmrn_checker u_mmrn_checker (.*);

`default_nettype wire

// ----- verif/min_max_range_normalizer_test.sv -----
// Self-checking testbench for min_max_range_normalizer: directed and random sequences with
// an internal predictor of the rescaled output stream, under several stall patterns.
// Depends on mmrn_pkg and the min_max_range_normalizer RTL.
module min_max_range_normalizer_test;
    import mmrn_pkg::*;

    localparam int unsigned SEQ_DEPTH    = SEQ_DEPTH_DEF;
    localparam int          DRAIN_SETTLE = 40;
    localparam int          DRAIN_LIMIT  = 100000;

    typedef struct packed {
        t_sample value;
        logic    last;
        logic    flat;
    } t_scaled_item;

    typedef enum {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME,
        SPREAD_FLAT
    } t_sample_spread;

    logic                   i_clk             = 1'b0;
    logic                   i_rst_n           = 1'b0;
    logic                   i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx         = REG_OUT_MIN;
    logic [DATA_W-1:0]      i_cfg_data        = '0;
    logic                   i_in_valid        = 1'b0;
    logic                   o_in_stall;
    t_sample                i_sample          = '0;
    logic                   i_end_of_sequence = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall       = 1'b0;
    t_sample                o_scaled_value;
    logic                   o_last_of_run;
    logic                   o_flat_input;

    t_sample      seq_store [SEQ_DEPTH];
    int unsigned  seq_count = 0;
    t_sample      seq_lo    = '0;
    t_sample      seq_hi    = '0;
    t_sample      out_lo    = '0;
    t_sample      out_hi    = '0;
    t_scaled_item pending_scaled [$];

    int send_idle_pct      = 0;
    int recv_stall_pct     = 0;
    int receiver_hold_left = 0;
    int mismatch_count     = 0;
    int samples_accepted   = 0;
    int results_checked    = 0;
    int runs_closed        = 0;
    int flat_runs          = 0;
    int range_settings     = 0;

    min_max_range_normalizer #(
        .SEQ_DEPTH(SEQ_DEPTH)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample          (i_sample),
        .i_end_of_sequence (i_end_of_sequence),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_scaled_value    (o_scaled_value),
        .o_last_of_run     (o_last_of_run),
        .o_flat_input      (o_flat_input)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_sample rescale_sample(t_sample x);
        longint span_in;
        longint span_out;
        longint diff;
        longint r;
        span_in  = longint'(seq_hi) - longint'(seq_lo);
        span_out = longint'(out_hi) - longint'(out_lo);
        diff     = longint'(x) - longint'(seq_lo);
        r        = longint'(out_lo) + (diff * span_out) / span_in;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return t_sample'(r);
    endfunction

    function automatic void absorb_sample(t_sample x, logic eos);
        logic         flat;
        t_scaled_item item;
        if (seq_count >= SEQ_DEPTH)
            seq_count = 0;
        if (seq_count == 0) begin
            seq_lo = x;
            seq_hi = x;
        end else if (x < seq_lo) begin
            seq_lo = x;
        end else if (x > seq_hi) begin
            seq_hi = x;
        end
        seq_store[seq_count] = x;
        seq_count++;
        if (!eos && seq_count < SEQ_DEPTH)
            return;
        flat = (seq_hi == seq_lo);
        for (int unsigned k = 0; k < seq_count; k++) begin
            item.value = flat ? out_lo : rescale_sample(seq_store[k]);
            item.last  = (k + 1 == seq_count);
            item.flat  = flat;
            pending_scaled.push_back(item);
        end
        runs_closed++;
        if (flat)
            flat_runs++;
        seq_count = 0;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_OUT_MIN)
                    out_lo = t_sample'(i_cfg_data);
                else if (i_cfg_idx == REG_OUT_MAX)
                    out_hi = t_sample'(i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                samples_accepted++;
                absorb_sample(i_sample, i_end_of_sequence);
            end
        end
    end

    always @(posedge i_clk) begin
        t_scaled_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_scaled.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected item value %0d last %0b flat %0b",
                             $time, o_scaled_value, o_last_of_run, o_flat_input);
            end else begin
                want = pending_scaled.pop_front();
                results_checked++;
                if (want.value !== o_scaled_value || want.last !== o_last_of_run
                        || want.flat !== o_flat_input) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected value %0d last %0b flat %0b, got %0d %0b %0b",
                                 $time, want.value, want.last, want.flat,
                                 o_scaled_value, o_last_of_run, o_flat_input);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (receiver_hold_left > 0) begin
            receiver_hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_sample(t_sample s, logic eos);
        int idle;
        idle = 0;
        while (idle < 60 && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            idle++;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_sample          <= s;
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drain(int settle);
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_scaled.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic set_output_range(t_sample lo, t_sample hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_OUT_MIN;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= REG_OUT_MAX;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        range_settings++;
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    function automatic t_sample pick_sample(t_sample_spread spread, int base);
        case (spread)
            SPREAD_NARROW:
                return t_sample'(base + int'($urandom_range(0, 15)) - 8);
            SPREAD_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            SPREAD_FLAT:
                return t_sample'(base);
            default:
                return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_random_sequence(output int len);
        int             r;
        int             base;
        t_sample_spread spread;
        r = $urandom_range(99);
        if (r < 70)
            len = $urandom_range(1, 12);
        else if (r < 90)
            len = $urandom_range(13, 40);
        else if (r < 97)
            len = $urandom_range(41, SEQ_DEPTH);
        else
            len = $urandom_range(SEQ_DEPTH + 1, SEQ_DEPTH + 16);
        r    = $urandom_range(99);
        base = int'($urandom_range(0, 65535)) - 32768;
        if (r < 45)
            spread = SPREAD_FULL;
        else if (r < 75)
            spread = SPREAD_NARROW;
        else if (r < 85)
            spread = SPREAD_EXTREME;
        else
            spread = SPREAD_FLAT;
        for (int i = 0; i < len; i++)
            send_sample(pick_sample(spread, base), i == len - 1);
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sh0100, 1'b0);
        send_sample(-16'sh0200, 1'b0);
        send_sample(16'sh0050, 1'b1);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_extremes();
        set_output_range(16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shffff, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shaaaa, 1'b1);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_flat_runs();
        set_output_range(-16'sh1234, 16'sh4321);
        send_sample(16'sh007b, 1'b1);
        send_sample(16'sh0005, 1'b0);
        send_sample(16'sh0005, 1'b0);
        send_sample(16'sh0005, 1'b1);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_reversed_range();
        set_output_range(16'sh03e8, -16'sh03e8);
        send_sample(-16'sh0064, 1'b0);
        send_sample(16'sh012c, 1'b0);
        send_sample(16'sh0032, 1'b0);
        send_sample(16'sh0000, 1'b1);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_full_buffer();
        set_output_range(-16'sh4000, 16'sh3fff);
        for (int i = 0; i < SEQ_DEPTH + 3; i++)
            send_sample(pick_sample(SPREAD_FULL, 0), i == SEQ_DEPTH + 2);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_backpressure();
        set_output_range(16'sh8000, 16'sh7fff);
        set_idling(0, 0);
        @(posedge i_clk);
        receiver_hold_left = 400;
        for (int s = 0; s < 6; s++)
            for (int i = 0; i < 8; i++)
                send_sample(pick_sample(SPREAD_FULL, 0), i == 7);
        for (int i = 0; i < 5; i++)
            send_sample(pick_sample(SPREAD_FULL, 0), 1'b0);
        wait_drain(0);
        for (int i = 0; i < 3; i++)
            send_sample(pick_sample(SPREAD_FULL, 0), i == 2);
        wait_drain(DRAIN_SETTLE);
    endtask

    task automatic test_random();
        int      phase_items;
        int      len;
        t_sample lo;
        t_sample hi;
        for (int phase = 0; phase < 8; phase++) begin
            lo = t_sample'($urandom_range(0, 65535));
            hi = t_sample'($urandom_range(0, 65535));
            case (phase)
                0: begin lo = 16'sh8000; hi = 16'sh7fff; end
                1: begin lo = 16'sh7fff; hi = 16'sh8000; end
                3: begin lo = 16'sh8000; hi = 16'sh8000; end
                5: begin lo = 16'sh0000; hi = 16'sh0001; end
                default: ;
            endcase
            set_output_range(lo, hi);
            case (phase % 4)
                0: set_idling(0, 0);
                1: set_idling(80, 0);
                2: set_idling(0, 80);
                default: set_idling(26, 26);
            endcase
            phase_items = 0;
            while (phase_items < 28) begin
                send_random_sequence(len);
                phase_items += len;
            end
            wait_drain(DRAIN_SETTLE);
        end
        set_idling(0, 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extremes();
        test_flat_runs();
        test_reversed_range();
        test_full_buffer();
        test_backpressure();
        test_random();
        wait_drain(DRAIN_SETTLE);
        if (pending_scaled.size() != 0) begin
            $display("%0d expected items never arrived", pending_scaled.size());
            mismatch_count += pending_scaled.size();
        end
        $display("Sent %0d samples in %0d runs (%0d flat) over %0d output ranges;",
                 samples_accepted, runs_closed, flat_runs, range_settings);
        $display("checked %0d rescaled items, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d items outstanding", pending_scaled.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mmrn_pkg.sv
rtl/mmrn_front.sv
rtl/mmrn_store.sv
rtl/mmrn_jobq.sv
rtl/mmrn_back.sv
rtl/min_max_range_normalizer.sv
rtl/mmrn_checker.sv
verif/min_max_range_normalizer_test.sv
